// ----- rtl/swls_pkg.sv -----
// Shared constants for the sliding-window latency statistics block.
`timescale 1ns / 1ps

package swls_pkg;

  // Event kinds carried on the input tuser
  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Window length register and reported sample count
  localparam int unsigned LEN_W       = 9;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;
  localparam int unsigned COUNT_OUT_W = 9;

  // Default sizing
  localparam int unsigned DEF_WINDOW_DEPTH = 256;
  localparam int unsigned DEF_TIME_WIDTH   = 48;

endpackage

// ----- rtl/swls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swls_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/swls_div.sv -----
// Restoring divider, one quotient bit per cycle through one shared subtractor.
`timescale 1ns / 1ps

module swls_div #(
  parameter int unsigned DIVIDEND_W = 57,
  parameter int unsigned DIVISOR_W  = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  take;

  // shared subtractor: shifted remainder minus divisor
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], take};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      quo_q  <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // remainder stays below the divisor while working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/sliding_window_latency_stats_top.sv -----
// Top level of the sliding-window latency statistics block.
`timescale 1ns / 1ps

// Latency monitor. Each input transfer is a timestamped event whose kind rides on
// s_axis_tuser: start latches the timestamp, stop measures stop minus start (modulo
// 2^TIME_WIDTH), clear resets min/max and empties the window (start time is kept).
// Only a stop produces an output transfer, carrying the current duration, the
// lifetime min and max since the last clear, the truncated average over the window
// and the number of samples held. The window is a ring of the last window_length
// durations held in one RAM; cfg_wdata_i sets window_length (0 acts as 1, values
// above WINDOW_DEPTH saturate). Lowering the length with samples held drops only
// one old sample per stop until a clear. Start, clear and unknown kinds are handled
// directly in the idle state. A stop steps through a check, an optional drop of the
// oldest sample, the push and a bit-serial divider that forms the average, one
// quotient bit per cycle; s_axis_tready is low until its result is loaded into the
// output register, which waits while an earlier result is still unaccepted. A
// finished result sits in the output register, so the next event can be taken while
// it waits.
module sliding_window_latency_stats_top
  import swls_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned TIME_WIDTH   = DEF_TIME_WIDTH,
  localparam int unsigned IN_DW  = ((TIME_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((4 * TIME_WIDTH + COUNT_OUT_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config: window_length
  input  logic                   cfg_we_i,
  input  logic [LEN_W-1:0]       cfg_wdata_i,
  // event input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DW-1:0]       s_axis_tdata,   // timestamp
  input  logic [KIND_W-1:0]      s_axis_tuser,   // kind
  // statistics output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DW-1:0]      m_axis_tdata    // current, min, max, average, count
);

  localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned EW      = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  // window total is TIME_WIDTH + CNT_W bits, capped at 64 like a plain 64-bit accumulator
  localparam int unsigned TOTAL_W = (TIME_WIDTH + CNT_W > 64) ? 64 : TIME_WIDTH + CNT_W;
  localparam int unsigned PAD_W   = OUT_DW - 4 * TIME_WIDTH - COUNT_OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_DROP,
    ST_PUSH,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic [LEN_W-1:0]       win_len_q;
  logic [TIME_WIDTH-1:0]  start_q;
  logic [TIME_WIDTH-1:0]  dur_q;
  logic [IDX_W-1:0]       oldest_q;
  logic [IDX_W-1:0]       slot_q;
  logic [CNT_W-1:0]       held_q;
  logic [TOTAL_W-1:0]     total_q;
  logic [TIME_WIDTH-1:0]  min_q;
  logic [TIME_WIDTH-1:0]  max_q;

  logic                   m_valid_q;
  logic [TIME_WIDTH-1:0]  cur_out_q;
  logic [TIME_WIDTH-1:0]  min_out_q;
  logic [TIME_WIDTH-1:0]  max_out_q;
  logic [TIME_WIDTH-1:0]  avg_out_q;
  logic [COUNT_OUT_W-1:0] cnt_out_q;

  logic                   in_xfer;
  logic [TIME_WIDTH-1:0]  in_ts;
  logic [EW-1:0]          len_ext;
  logic [EW-1:0]          eff_len;
  logic                   drop;
  logic [CNT_W:0]         slot_sum;
  logic [CNT_W:0]         slot_wrap;
  logic [IDX_W-1:0]       oldest_nxt;

  logic                   ram_we;
  logic                   ram_re;
  logic [TIME_WIDTH-1:0]  ram_rdata;

  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [TOTAL_W-1:0]     div_quo;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_ts         = s_axis_tdata[TIME_WIDTH-1:0];

  // effective window length: zero acts as one, clamp at the RAM depth
  always_comb begin
    len_ext = EW'(win_len_q);
    if (len_ext == '0) begin
      eff_len = EW'(1);
    end else if (len_ext > EW'(WINDOW_DEPTH)) begin
      eff_len = EW'(WINDOW_DEPTH);
    end else begin
      eff_len = len_ext;
    end
  end

  assign drop = (EW'(held_q) >= eff_len) && (held_q != '0);

  // write slot is oldest + held either way: a drop moves oldest up and held down
  always_comb begin
    slot_sum  = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(held_q);
    slot_wrap = slot_sum;
    if (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
      slot_wrap = slot_sum - (CNT_W + 1)'(WINDOW_DEPTH);
    end
  end

  assign oldest_nxt = (oldest_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);

  assign ram_re    = (state_q == ST_CHK) && drop;
  assign ram_we    = (state_q == ST_PUSH);
  assign div_start = (state_q == ST_DIVGO);

  swls_ram #(
    .WIDTH (TIME_WIDTH),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (dur_q),
    .re_i    (ram_re),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  swls_div #(
    .DIVIDEND_W (TOTAL_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q),
    .divisor_i  (held_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer, statistics state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      win_len_q <= LEN_RESET;
      start_q   <= '0;
      dur_q     <= '0;
      oldest_q  <= '0;
      slot_q    <= '0;
      held_q    <= '0;
      total_q   <= '0;
      min_q     <= '1;
      max_q     <= '0;
      m_valid_q <= 1'b0;
      cur_out_q <= '0;
      min_out_q <= '0;
      max_out_q <= '0;
      avg_out_q <= '0;
      cnt_out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
      end
      // in ST_OUT the result load below decides the valid flag
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            case (s_axis_tuser)
              KIND_START: begin
                start_q <= in_ts;
              end
              KIND_STOP: begin
                dur_q   <= in_ts - start_q;
                state_q <= ST_CHK;
              end
              KIND_CLEAR: begin
                oldest_q <= '0;
                held_q   <= '0;
                total_q  <= '0;
                min_q    <= '1;
                max_q    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CHK: begin
          slot_q  <= slot_wrap[IDX_W-1:0];
          state_q <= drop ? ST_DROP : ST_PUSH;
        end
        ST_DROP: begin
          total_q  <= total_q - TOTAL_W'(ram_rdata);
          oldest_q <= oldest_nxt;
          held_q   <= held_q - CNT_W'(1);
          state_q  <= ST_PUSH;
        end
        ST_PUSH: begin
          held_q  <= held_q + CNT_W'(1);
          total_q <= total_q + TOTAL_W'(dur_q);
          if (dur_q > max_q) begin
            max_q <= dur_q;
          end
          if (dur_q < min_q) begin
            min_q <= dur_q;
          end
          state_q <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            cur_out_q <= dur_q;
            min_out_q <= min_q;
            max_out_q <= max_q;
            avg_out_q <= TIME_WIDTH'(div_quo);
            cnt_out_q <= COUNT_OUT_W'(held_q);
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, cnt_out_q, avg_out_q, max_out_q, min_out_q,
                          cur_out_q};

  // window never holds more samples than the RAM has entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(WINDOW_DEPTH))
    else $error("held count exceeds window depth");

  // divider is idle whenever a new event can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy)
    else $error("divider busy while accepting events");

  // a clear empties the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser == KIND_CLEAR) |=> (held_q == '0 && total_q == '0))
    else $error("clear did not empty the window");

  // reported current duration lies between the reported min and max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (min_out_q <= cur_out_q && cur_out_q <= max_out_q))
    else $error("current duration outside min/max");

  // a result is only loaded at the end of a stop sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_valid_q ##1 m_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("output loaded outside result state");

endmodule
